>>> hw/rtl/rbei_pkg.sv
// Shared types, constants and saturating arithmetic helpers for the rigid body integrator.
package rbei_pkg;

    // Fixed-point format of vectors, velocities, gravity and coefficients.
    localparam int FRAC_BITS = 16;
    // Frame time is always unsigned Q0.16.
    localparam int DT_BITS   = 16;
    localparam int WORD_W    = 32;
    localparam int B_W       = WORD_W + 1;
    localparam int PROD_W    = WORD_W + B_W;
    localparam int COEF_W    = 31;
    localparam int FACT_W    = FRAC_BITS + 1;
    localparam int AXES      = 3;
    localparam int AX_X      = 0;
    localparam int AX_Y      = 1;
    localparam int AX_Z      = 2;

    localparam logic [FACT_W-1:0] ONE = FACT_W'(1) << FRAC_BITS;
    // Speed below which a grounded body is snapped to rest, as a squared magnitude.
    localparam logic [63:0] SNAP_THR = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    // Kind of an input item.
    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_FORCE   = 2'd1,
        KIND_IMPULSE = 2'd2,
        KIND_VCHG    = 2'd3
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_INV_MASS  = 3'd0,
        CFG_GSCALE    = 3'd1,
        CFG_DRAG      = 3'd2,
        CFG_GFRICTION = 3'd3,
        CFG_MODE      = 3'd4,
        CFG_GRAVITY_X = 3'd5,
        CFG_GRAVITY_Y = 3'd6,
        CFG_GRAVITY_Z = 3'd7
    } cfg_idx_t;

    // Write-back operation of a lane.
    typedef enum logic [2:0] {
        LOP_NOP,
        LOP_ACC_ADD,
        LOP_VEL_ADD,
        LOP_VEL_SET,
        LOP_CLAMP,
        LOP_CLEAR,
        LOP_ACC_CLR,
        LOP_VEL_ZERO
    } lane_op_t;

    // First multiplier operand of a lane.
    typedef enum logic [1:0] {
        ASEL_VEC,
        ASEL_GRAV,
        ASEL_ACC,
        ASEL_VEL
    } a_sel_t;

    // Command from the sequencer to one lane.
    typedef struct packed {
        logic                  issue;
        lane_op_t              op;
        a_sel_t                a_sel;
        logic                  b_own;
        logic signed [B_W-1:0] b_val;
        logic                  sh_dt;
    } lane_cmd_t;

    // Controls from the sequencer to the merging stage.
    typedef struct packed {
        logic snap_load;
        logic disp_load;
        logic out_load;
        logic moved;
    } merge_ctrl_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_KIN,
        ST_CLAMP,
        ST_GRAV,
        ST_INTEG,
        ST_DRAG,
        ST_FRIC,
        ST_SQ,
        ST_SNAP,
        ST_DISP,
        ST_PUSH
    } state_t;

    // Floor shift of a product, then saturation to a signed word.
    function automatic logic signed [WORD_W-1:0] sat_shift(
        input logic signed [PROD_W-1:0] p,
        input logic                     sh_dt
    );
        logic signed [PROD_W-1:0] s;
        s = sh_dt ? (p >>> DT_BITS) : (p >>> FRAC_BITS);
        if (!s[PROD_W-1] && (|s[PROD_W-2:WORD_W-1])) begin
            return WORD_MAX;
        end else if (s[PROD_W-1] && !(&s[PROD_W-2:WORD_W-1])) begin
            return WORD_MIN;
        end else begin
            return s[WORD_W-1:0];
        end
    endfunction

    // Saturating sum of two signed words.
    function automatic logic signed [WORD_W-1:0] sat_add(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        logic signed [WORD_W:0] s;
        s = (WORD_W+1)'(a) + (WORD_W+1)'(b);
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        end else begin
            return s[WORD_W-1:0];
        end
    endfunction

endpackage

>>> hw/rtl/rbei_factor.sv
// Damping factor unit: max(0, ONE - coeff*dt) over a two-stage pipeline.
module rbei_factor (
    input  logic                                  aclk,
    input  logic [rbei_pkg::COEF_W-1:0]           coeff,
    input  logic [rbei_pkg::DT_BITS-1:0]          dt,
    output logic [rbei_pkg::FACT_W-1:0]           factor
);

    localparam int P_W = rbei_pkg::COEF_W + rbei_pkg::DT_BITS;

    logic [P_W-1:0]                  prod_reg;
    logic [rbei_pkg::COEF_W-1:0]     scaled;
    logic [rbei_pkg::FACT_W-1:0]     factor_next;
    logic [rbei_pkg::FACT_W-1:0]     factor_reg;

    // Product of the coefficient and the frame time.
    always_ff @(posedge aclk) begin
        prod_reg <= P_W'(coeff) * P_W'(dt);
    end

    // Remove the frame time fraction and clamp the factor at zero.
    always_comb begin
        scaled = prod_reg[P_W-1:rbei_pkg::DT_BITS];
        if (scaled >= rbei_pkg::COEF_W'(rbei_pkg::ONE)) begin
            factor_next = '0;
        end else begin
            factor_next = rbei_pkg::ONE - scaled[rbei_pkg::FACT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        factor_reg <= factor_next;
    end

    assign factor = factor_reg;

endmodule

>>> hw/rtl/rbei_lane.sv
// One axis lane: velocity and acceleration state with a shared multiply and write-back.
module rbei_lane (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  rbei_pkg::lane_cmd_t                    cmd,
    input  logic signed [rbei_pkg::WORD_W-1:0]     vec_in,
    input  logic signed [rbei_pkg::WORD_W-1:0]     grav_in,
    output logic signed [rbei_pkg::WORD_W-1:0]     vel_out,
    output logic signed [rbei_pkg::WORD_W-1:0]     res_out,
    output logic signed [rbei_pkg::PROD_W-1:0]     prod_out
);

    logic signed [rbei_pkg::WORD_W-1:0] vel_reg, vel_next;
    logic signed [rbei_pkg::WORD_W-1:0] acc_reg, acc_next;
    logic signed [rbei_pkg::PROD_W-1:0] prod_reg;
    logic                               sh_dt_reg;
    rbei_pkg::lane_op_t                 op_reg, op_next;

    logic signed [rbei_pkg::WORD_W-1:0] a_op;
    logic signed [rbei_pkg::B_W-1:0]    b_op;
    logic signed [rbei_pkg::PROD_W-1:0] a_ext;
    logic signed [rbei_pkg::PROD_W-1:0] b_ext;
    logic signed [rbei_pkg::WORD_W-1:0] res;

    // Operand selection for the multiplier.
    always_comb begin
        case (cmd.a_sel)
            rbei_pkg::ASEL_VEC:  a_op = vec_in;
            rbei_pkg::ASEL_GRAV: a_op = grav_in;
            rbei_pkg::ASEL_ACC:  a_op = acc_reg;
            rbei_pkg::ASEL_VEL:  a_op = vel_reg;
            default:             a_op = vec_in;
        endcase
        b_op  = cmd.b_own ? {vel_reg[rbei_pkg::WORD_W-1], vel_reg} : cmd.b_val;
        a_ext = rbei_pkg::PROD_W'(a_op);
        b_ext = rbei_pkg::PROD_W'(b_op);
        op_next = cmd.issue ? cmd.op : rbei_pkg::LOP_NOP;
    end

    // Issue stage: the product and the pending operation are registered.
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            prod_reg  <= a_ext * b_ext;
            sh_dt_reg <= cmd.sh_dt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= rbei_pkg::LOP_NOP;
        end else begin
            op_reg <= op_next;
        end
    end

    // Write-back stage: scale the product and update the state.
    always_comb begin
        res      = rbei_pkg::sat_shift(prod_reg, sh_dt_reg);
        vel_next = vel_reg;
        acc_next = acc_reg;
        case (op_reg)
            rbei_pkg::LOP_ACC_ADD:  acc_next = rbei_pkg::sat_add(acc_reg, res);
            rbei_pkg::LOP_VEL_ADD:  vel_next = rbei_pkg::sat_add(vel_reg, res);
            rbei_pkg::LOP_VEL_SET:  vel_next = res;
            rbei_pkg::LOP_CLAMP:    vel_next = vel_reg[rbei_pkg::WORD_W-1] ? '0 : vel_reg;
            rbei_pkg::LOP_CLEAR: begin
                vel_next = '0;
                acc_next = '0;
            end
            rbei_pkg::LOP_ACC_CLR:  acc_next = '0;
            rbei_pkg::LOP_VEL_ZERO: vel_next = '0;
            default: begin
                vel_next = vel_reg;
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_reg <= '0;
            acc_reg <= '0;
        end else begin
            vel_reg <= vel_next;
            acc_reg <= acc_next;
        end
    end

    assign vel_out  = vel_reg;
    assign res_out  = res;
    assign prod_out = prod_reg;

endmodule

>>> hw/rtl/rbei_merge.sv
// Merging stage: speed snap test over the horizontal lanes and the result register.
module rbei_merge (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  rbei_pkg::merge_ctrl_t                  ctrl,
    input  logic signed [rbei_pkg::WORD_W-1:0]     vel_in [rbei_pkg::AXES],
    input  logic signed [rbei_pkg::WORD_W-1:0]     res_in [rbei_pkg::AXES],
    input  logic signed [rbei_pkg::PROD_W-1:0]     sq_x,
    input  logic signed [rbei_pkg::PROD_W-1:0]     sq_z,
    output logic                                   snap,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // disp_x, disp_y, disp_z, vel_x, vel_y, vel_z
    output logic [6*rbei_pkg::WORD_W-1:0]          m_tdata,
    // moved
    output logic                                   m_tuser
);

    logic [63:0]                        sq_sum;
    logic                               snap_reg;
    logic signed [rbei_pkg::WORD_W-1:0] disp_reg     [rbei_pkg::AXES];
    logic signed [rbei_pkg::WORD_W-1:0] out_disp_reg [rbei_pkg::AXES];
    logic signed [rbei_pkg::WORD_W-1:0] out_vel_reg  [rbei_pkg::AXES];
    logic                               moved_reg;
    logic                               valid_reg, valid_next;

    // Squared horizontal speed; both squares are non-negative.
    assign sq_sum = {1'b0, sq_x[62:0]} + {1'b0, sq_z[62:0]};

    always_ff @(posedge aclk) begin
        if (ctrl.snap_load) begin
            snap_reg <= (sq_sum <= rbei_pkg::SNAP_THR);
        end
    end

    // Displacement from each lane's scaled product.
    always_ff @(posedge aclk) begin
        if (ctrl.disp_load) begin
            for (int i = 0; i < rbei_pkg::AXES; i++) begin
                disp_reg[i] <= res_in[i];
            end
        end
    end

    // Output register; a finished result waits here until taken.
    always_comb begin
        valid_next = valid_reg;
        if (ctrl.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            moved_reg <= ctrl.moved;
            for (int i = 0; i < rbei_pkg::AXES; i++) begin
                out_disp_reg[i] <= ctrl.moved ? disp_reg[i] : '0;
                out_vel_reg[i]  <= vel_in[i];
            end
        end
    end

    assign snap     = snap_reg;
    assign m_tvalid = valid_reg;
    assign m_tuser  = moved_reg;
    assign m_tdata  = {out_vel_reg[rbei_pkg::AX_Z], out_vel_reg[rbei_pkg::AX_Y],
                       out_vel_reg[rbei_pkg::AX_X], out_disp_reg[rbei_pkg::AX_Z],
                       out_disp_reg[rbei_pkg::AX_Y], out_disp_reg[rbei_pkg::AX_X]};

endmodule

>>> hw/rtl/rigid_body_euler_integrator_core.sv
// Top level of the one-body semi-implicit Euler integrator with linear drag.
//
// Each input item is taken in the idle state and worked on alone. Three axis lanes, each
// with one 32x33 multiplier, work side by side; each step forms a product and then writes
// it back. A force, impulse or velocity-change item updates the lanes and gives no result.
// A tick on a kinematic body clears its velocity and acceleration; any other tick runs the
// clamp, gravity, integration, drag and displacement steps, and on a grounded body with
// nonzero ground friction, friction, horizontal speed test and snap add three steps. A tick
// waits while the previous result is still in the output register. Every tick gives one
// result. Configuration writes land at once and must only be made while the block is idle.
module rigid_body_euler_integrator_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // vec_x, vec_y, vec_z, dt, grounded, attached, zero padding
    input  logic [119:0]  s_tdata,
    // kind
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // disp_x, disp_y, disp_z, vel_x, vel_y, vel_z
    output logic [191:0]  m_tdata,
    // moved
    output logic          m_tuser,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_wdata
);

    localparam int W = rbei_pkg::WORD_W;

    // Configuration registers.
    logic [rbei_pkg::COEF_W-1:0] inv_mass_reg;
    logic signed [W-1:0]         gscale_reg;
    logic [rbei_pkg::COEF_W-1:0] drag_reg;
    logic [rbei_pkg::COEF_W-1:0] gfric_reg;
    logic [1:0]                  mode_reg;
    logic signed [W-1:0]         grav_reg [rbei_pkg::AXES];

    // Accepted item.
    rbei_pkg::kind_t             kind_reg;
    logic signed [W-1:0]         vec_reg [rbei_pkg::AXES];
    logic [rbei_pkg::DT_BITS-1:0] dt_reg;
    logic                        grounded_reg;
    logic                        attached_reg;

    // Sequencer.
    rbei_pkg::state_t            state_reg, state_next;
    logic                        phase_reg, phase_next;
    rbei_pkg::lane_cmd_t         cmd [rbei_pkg::AXES];
    rbei_pkg::merge_ctrl_t       mctrl;

    logic [rbei_pkg::FACT_W-1:0] f_drag;
    logic [rbei_pkg::FACT_W-1:0] f_gnd;
    logic signed [W-1:0]         vel   [rbei_pkg::AXES];
    logic signed [W-1:0]         res   [rbei_pkg::AXES];
    logic signed [rbei_pkg::PROD_W-1:0] prod [rbei_pkg::AXES];
    logic                        snap;
    logic                        accept;
    logic                        gate;
    logic                        fric_en;
    logic                        out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;
    assign fric_en  = grounded_reg && (gfric_reg != '0);
    assign gate     = mode_reg[1] &&
                      !(grounded_reg && (vel[rbei_pkg::AX_Y][W-1] || (vel[rbei_pkg::AX_Y] == '0)));

    // Configuration write port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_mass_reg                 <= 31'd65536;
            gscale_reg                   <= 32'sd65536;
            drag_reg                     <= '0;
            gfric_reg                    <= '0;
            mode_reg                     <= 2'd2;
            grav_reg[rbei_pkg::AX_X]     <= '0;
            grav_reg[rbei_pkg::AX_Y]     <= -32'sd642253;
            grav_reg[rbei_pkg::AX_Z]     <= '0;
        end else if (cfg_wr_en) begin
            case (rbei_pkg::cfg_idx_t'(cfg_index))
                rbei_pkg::CFG_INV_MASS:  inv_mass_reg <= cfg_wdata[rbei_pkg::COEF_W-1:0];
                rbei_pkg::CFG_GSCALE:    gscale_reg   <= cfg_wdata;
                rbei_pkg::CFG_DRAG:      drag_reg     <= cfg_wdata[rbei_pkg::COEF_W-1:0];
                rbei_pkg::CFG_GFRICTION: gfric_reg    <= cfg_wdata[rbei_pkg::COEF_W-1:0];
                rbei_pkg::CFG_MODE:      mode_reg     <= cfg_wdata[1:0];
                rbei_pkg::CFG_GRAVITY_X: grav_reg[rbei_pkg::AX_X] <= cfg_wdata;
                rbei_pkg::CFG_GRAVITY_Y: grav_reg[rbei_pkg::AX_Y] <= cfg_wdata;
                rbei_pkg::CFG_GRAVITY_Z: grav_reg[rbei_pkg::AX_Z] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input item capture.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg                <= rbei_pkg::kind_t'(s_tuser);
            vec_reg[rbei_pkg::AX_X] <= s_tdata[31:0];
            vec_reg[rbei_pkg::AX_Y] <= s_tdata[63:32];
            vec_reg[rbei_pkg::AX_Z] <= s_tdata[95:64];
            dt_reg                  <= s_tdata[111:96];
            grounded_reg            <= s_tdata[112];
            attached_reg            <= s_tdata[113];
        end
    end

    // Drag and ground damping factors follow the captured frame time.
    rbei_factor u_drag_factor (
        .aclk   (aclk),
        .coeff  (drag_reg),
        .dt     (dt_reg),
        .factor (f_drag)
    );

    rbei_factor u_gnd_factor (
        .aclk   (aclk),
        .coeff  (gfric_reg),
        .dt     (dt_reg),
        .factor (f_gnd)
    );

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbei_pkg::ST_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Next state and lane commands; each step issues in phase 0 and writes back in phase 1.
    always_comb begin
        state_next = state_reg;
        phase_next = 1'b0;
        s_tready   = 1'b0;
        mctrl      = '{snap_load: 1'b0, disp_load: 1'b0, out_load: 1'b0,
                       moved: attached_reg && !mode_reg[0]};
        for (int i = 0; i < rbei_pkg::AXES; i++) begin
            cmd[i] = '{issue: 1'b0, op: rbei_pkg::LOP_NOP, a_sel: rbei_pkg::ASEL_VEC,
                       b_own: 1'b0, b_val: '0, sh_dt: 1'b0};
        end

        case (state_reg)
            rbei_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (rbei_pkg::kind_t'(s_tuser) == rbei_pkg::KIND_TICK) begin
                        state_next = mode_reg[0] ? rbei_pkg::ST_KIN : rbei_pkg::ST_CLAMP;
                    end else begin
                        state_next = rbei_pkg::ST_UPD;
                    end
                end
            end

            rbei_pkg::ST_UPD: begin
                for (int i = 0; i < rbei_pkg::AXES; i++) begin
                    cmd[i].issue = !phase_reg;
                    cmd[i].a_sel = rbei_pkg::ASEL_VEC;
                    case (kind_reg)
                        rbei_pkg::KIND_FORCE: begin
                            cmd[i].op    = rbei_pkg::LOP_ACC_ADD;
                            cmd[i].b_val = rbei_pkg::B_W'(inv_mass_reg);
                        end
                        rbei_pkg::KIND_IMPULSE: begin
                            cmd[i].op    = rbei_pkg::LOP_VEL_ADD;
                            cmd[i].b_val = rbei_pkg::B_W'(inv_mass_reg);
                        end
                        rbei_pkg::KIND_VCHG: begin
                            cmd[i].op    = rbei_pkg::LOP_VEL_ADD;
                            cmd[i].b_val = rbei_pkg::B_W'(rbei_pkg::ONE);
                        end
                        default: cmd[i].op = rbei_pkg::LOP_NOP;
                    endcase
                end
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = rbei_pkg::ST_IDLE;
                end
            end

            rbei_pkg::ST_KIN: begin
                for (int i = 0; i < rbei_pkg::AXES; i++) begin
                    cmd[i].issue = !phase_reg;
                    cmd[i].op    = rbei_pkg::LOP_CLEAR;
                end
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = rbei_pkg::ST_PUSH;
                end
            end

            // A grounded body does not keep falling.
            rbei_pkg::ST_CLAMP: begin
                cmd[rbei_pkg::AX_Y].issue = !phase_reg;
                cmd[rbei_pkg::AX_Y].op    = grounded_reg ? rbei_pkg::LOP_CLAMP
                                                         : rbei_pkg::LOP_NOP;
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = rbei_pkg::ST_GRAV;
                end
            end

            rbei_pkg::ST_GRAV: begin
                for (int i = 0; i < rbei_pkg::AXES; i++) begin
                    cmd[i].issue = !phase_reg;
                    cmd[i].op    = gate ? rbei_pkg::LOP_ACC_ADD : rbei_pkg::LOP_NOP;
                    cmd[i].a_sel = rbei_pkg::ASEL_GRAV;
                    cmd[i].b_val = rbei_pkg::B_W'(gscale_reg);
                end
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = rbei_pkg::ST_INTEG;
                end
            end

            rbei_pkg::ST_INTEG: begin
                for (int i = 0; i < rbei_pkg::AXES; i++) begin
                    cmd[i].issue = !phase_reg;
                    cmd[i].op    = rbei_pkg::LOP_VEL_ADD;
                    cmd[i].a_sel = rbei_pkg::ASEL_ACC;
                    cmd[i].b_val = rbei_pkg::B_W'(dt_reg);
                    cmd[i].sh_dt = 1'b1;
                end
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = rbei_pkg::ST_DRAG;
                end
            end

            rbei_pkg::ST_DRAG: begin
                for (int i = 0; i < rbei_pkg::AXES; i++) begin
                    cmd[i].issue = !phase_reg;
                    cmd[i].op    = rbei_pkg::LOP_VEL_SET;
                    cmd[i].a_sel = rbei_pkg::ASEL_VEL;
                    cmd[i].b_val = rbei_pkg::B_W'(f_drag);
                end
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = fric_en ? rbei_pkg::ST_FRIC : rbei_pkg::ST_DISP;
                end
            end

            // Ground friction damps the horizontal axes only.
            rbei_pkg::ST_FRIC: begin
                for (int i = 0; i < rbei_pkg::AXES; i++) begin
                    if (i != rbei_pkg::AX_Y) begin
                        cmd[i].issue = !phase_reg;
                        cmd[i].op    = rbei_pkg::LOP_VEL_SET;
                        cmd[i].a_sel = rbei_pkg::ASEL_VEL;
                        cmd[i].b_val = rbei_pkg::B_W'(f_gnd);
                    end
                end
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = rbei_pkg::ST_SQ;
                end
            end

            // Square the horizontal speeds; the merging stage compares their sum.
            rbei_pkg::ST_SQ: begin
                for (int i = 0; i < rbei_pkg::AXES; i++) begin
                    if (i != rbei_pkg::AX_Y) begin
                        cmd[i].issue = !phase_reg;
                        cmd[i].a_sel = rbei_pkg::ASEL_VEL;
                        cmd[i].b_own = 1'b1;
                    end
                end
                mctrl.snap_load = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = rbei_pkg::ST_SNAP;
                end
            end

            rbei_pkg::ST_SNAP: begin
                for (int i = 0; i < rbei_pkg::AXES; i++) begin
                    if (i != rbei_pkg::AX_Y) begin
                        cmd[i].issue = !phase_reg;
                        cmd[i].op    = snap ? rbei_pkg::LOP_VEL_ZERO : rbei_pkg::LOP_NOP;
                    end
                end
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = rbei_pkg::ST_DISP;
                end
            end

            // Displacement is velocity times frame time; the accumulator is cleared.
            rbei_pkg::ST_DISP: begin
                for (int i = 0; i < rbei_pkg::AXES; i++) begin
                    cmd[i].issue = !phase_reg;
                    cmd[i].op    = rbei_pkg::LOP_ACC_CLR;
                    cmd[i].a_sel = rbei_pkg::ASEL_VEL;
                    cmd[i].b_val = rbei_pkg::B_W'(dt_reg);
                    cmd[i].sh_dt = 1'b1;
                end
                mctrl.disp_load = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = rbei_pkg::ST_PUSH;
                end
            end

            rbei_pkg::ST_PUSH: begin
                if (out_free) begin
                    mctrl.out_load = 1'b1;
                    state_next     = rbei_pkg::ST_IDLE;
                end
            end

            default: state_next = rbei_pkg::ST_IDLE;
        endcase
    end

    // Axis lanes.
    for (genvar g = 0; g < rbei_pkg::AXES; g++) begin : g_lane
        rbei_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd[g]),
            .vec_in   (vec_reg[g]),
            .grav_in  (grav_reg[g]),
            .vel_out  (vel[g]),
            .res_out  (res[g]),
            .prod_out (prod[g])
        );
    end

    rbei_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mctrl),
        .vel_in   (vel),
        .res_in   (res),
        .sq_x     (prod[rbei_pkg::AX_X]),
        .sq_z     (prod[rbei_pkg::AX_Z]),
        .snap     (snap),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
